// File: rtl/twdt_pkg.sv
// ----------------------------------------------------------------------------
// twdt_pkg
// Shared types, codes and the command table for the text word decrypt
// tokenizer.
// ----------------------------------------------------------------------------
package twdt_pkg;

    // result kinds
    localparam logic [2:0] KIND_CHAR    = 3'd0;
    localparam logic [2:0] KIND_CMD     = 3'd1;
    localparam logic [2:0] KIND_PARAM   = 3'd2;
    localparam logic [2:0] KIND_UNKNOWN = 3'd3;
    localparam logic [2:0] KIND_EOL     = 3'd4;

    // key seeding and special text codes
    localparam logic [15:0] KEY_BASE     = 16'h7C89;
    localparam logic [15:0] KEY_STEP     = 16'h2983;
    localparam logic [15:0] CODE_CMD     = 16'hF000;
    localparam logic [15:0] CODE_EOL     = 16'hFFFF;
    localparam logic [15:0] CODE_HEART   = 16'h246D;
    localparam logic [15:0] CODE_HEART_R = 16'h2642;
    localparam logic [15:0] CODE_SPADE   = 16'h246E;
    localparam logic [15:0] CODE_SPADE_R = 16'h2640;
    localparam logic [15:0] CODE_NL      = 16'hFFFE;
    localparam logic [15:0] CODE_NL_R    = 16'h000A;
    localparam int unsigned KEY_ROT      = 3;

    // default depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // one result travelling from front to back
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] value;
        logic [15:0] param_count;
        logic        closes_command;
    } twdt_res_t;

    // command types that carry a parameter list
    function automatic logic is_known_cmd(input logic [15:0] t);
        logic hit;
        case (t) inside
            16'h0100, 16'h0101, 16'h0102, 16'h0103, 16'h0105, 16'h0106, 16'h0107,
            16'h0108, 16'h0109, 16'h010A, 16'h010B, 16'h010C, 16'h010D, 16'h010E,
            16'h010F, 16'h0110, 16'h0112, 16'h0113, 16'h011C, 16'h0122, 16'h0123,
            16'h0124, 16'h0125, 16'h0131, 16'h0132, 16'h0133, 16'h0134, 16'h0135,
            16'h0136, 16'h0137, 16'h013B, 16'h013C, 16'h013D, 16'h013E, 16'h013F,
            16'h0140, 16'h0142, 16'h0143, 16'h0189, 16'h018A, 16'h018B, 16'h018E,
            16'h018F, 16'h0190, 16'h0191, 16'h0192, 16'h0193, 16'h0195, 16'h0199,
            16'h019A, 16'h019B, 16'h019C, 16'h019F, 16'h01A1, 16'h0200, 16'h0201,
            16'h0202, 16'h0203, 16'h0204, 16'h0205, 16'h0206, 16'h0207, 16'h0208,
            16'h1000, 16'h1001, 16'h1100, 16'h1101, 16'h1302, 16'h1303, 16'hBD00,
            16'hBD01, 16'hBD02, 16'hBD03, 16'hBD04, 16'hBD05, 16'hBDFF, 16'hBE00,
            16'hBE01, 16'hBE02, 16'hBE09, 16'hFF00: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

// File: rtl/twdt_front.sv
// ----------------------------------------------------------------------------
// twdt_front
// Decrypts each accepted word with the rolling key and classifies it,
// tracking the line and command parse phase.
// ----------------------------------------------------------------------------
module twdt_front import twdt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_fire,
    input  logic        first_of_line,
    input  logic [15:0] line_index,
    input  logic [15:0] word,
    output logic        push,
    output twdt_res_t   push_data
);

    typedef enum logic [2:0] {
        PH_TEXT   = 3'd0,
        PH_TYPE   = 3'd1,
        PH_COUNT  = 3'd2,
        PH_PARAMS = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    logic [15:0] key_reg, key_next;
    phase_t      phase_reg, phase_next;
    logic [15:0] type_reg, type_next;
    logic [15:0] left_reg, left_next;

    logic [15:0] seed_prod;
    logic [15:0] key_cur, type_cur, left_cur, left_dec, plain;
    phase_t      phase_cur;
    logic        emit;
    twdt_res_t   res;

    // line start reseeds key and restarts parsing
    assign seed_prod = line_index * KEY_STEP;
    always_comb begin
        if (first_of_line) begin
            key_cur   = KEY_BASE + seed_prod;
            phase_cur = PH_TEXT;
            type_cur  = '0;
            left_cur  = '0;
        end else begin
            key_cur   = key_reg;
            phase_cur = phase_reg;
            type_cur  = type_reg;
            left_cur  = left_reg;
        end
    end

    assign plain    = word ^ key_cur;
    assign left_dec = left_cur - 16'd1;

    // phase update and result classification
    always_comb begin
        key_next   = key_cur;
        phase_next = phase_cur;
        type_next  = type_cur;
        left_next  = left_cur;
        emit       = 1'b0;
        res        = '{kind: KIND_CHAR, value: plain, param_count: '0,
                       closes_command: 1'b0};
        if (phase_cur != PH_DONE) begin
            key_next = {key_cur[15-KEY_ROT:0], key_cur[15:16-KEY_ROT]};
        end
        unique case (phase_cur)
            PH_DONE: begin
                emit = 1'b0;
            end
            PH_TYPE: begin
                type_next  = plain;
                phase_next = PH_COUNT;
            end
            PH_COUNT: begin
                emit = 1'b1;
                if (is_known_cmd(type_cur)) begin
                    left_next  = plain;
                    phase_next = (plain != 16'd0) ? PH_PARAMS : PH_TEXT;
                    res = '{kind: KIND_CMD, value: type_cur, param_count: plain,
                            closes_command: (plain == 16'd0)};
                end else begin
                    left_next  = '0;
                    phase_next = PH_TEXT;
                    res = '{kind: KIND_UNKNOWN, value: type_cur, param_count: '0,
                            closes_command: 1'b1};
                end
            end
            PH_PARAMS: begin
                emit      = 1'b1;
                left_next = left_dec;
                if (left_dec == 16'd0) phase_next = PH_TEXT;
                res = '{kind: KIND_PARAM, value: plain, param_count: '0,
                        closes_command: (left_dec == 16'd0)};
            end
            default: begin
                // text phase, unused codes behave the same
                phase_next = PH_TEXT;
                if (plain == CODE_EOL) begin
                    emit       = 1'b1;
                    phase_next = PH_DONE;
                    res = '{kind: KIND_EOL, value: '0, param_count: '0,
                            closes_command: 1'b0};
                end else if (plain == CODE_CMD) begin
                    phase_next = PH_TYPE;
                end else begin
                    emit = 1'b1;
                end
            end
        endcase
    end

    assign push      = in_fire && emit;
    assign push_data = res;

    // parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg   <= KEY_BASE;
            phase_reg <= PH_TEXT;
            type_reg  <= '0;
            left_reg  <= '0;
        end else if (in_fire) begin
            key_reg   <= key_next;
            phase_reg <= phase_next;
            type_reg  <= type_next;
            left_reg  <= left_next;
        end
    end

endmodule

// File: rtl/twdt_queue.sv
// ----------------------------------------------------------------------------
// twdt_queue
// Small first-in first-out queue of results between front and back.
// ----------------------------------------------------------------------------
module twdt_queue import twdt_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  twdt_res_t push_data,
    output logic      full,
    output logic      not_empty,
    input  logic      pop,
    output twdt_res_t pop_data
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    twdt_res_t         mem [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]     count_reg;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= push_data;
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)      count_reg <= count_reg + CW'(1);
            else if (pop && !push) count_reg <= count_reg - CW'(1);
        end
    end

endmodule

// File: rtl/twdt_back.sv
// ----------------------------------------------------------------------------
// twdt_back
// Applies the character remapping and holds the result in the output
// register until the receiver takes it.
// ----------------------------------------------------------------------------
module twdt_back import twdt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  twdt_res_t   q_data,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [15:0] m_value,
    output logic [15:0] m_param_count,
    output logic        m_closes_command
);

    logic        valid_reg;
    twdt_res_t   out_reg;
    logic [15:0] mapped;
    twdt_res_t   load_data;

    // load when the output register is empty or being drained
    assign q_pop = q_valid && (!valid_reg || m_ready);

    // remap the three special character codes
    always_comb begin
        mapped = q_data.value;
        if (q_data.kind == KIND_CHAR) begin
            case (q_data.value)
                CODE_HEART: mapped = CODE_HEART_R;
                CODE_SPADE: mapped = CODE_SPADE_R;
                CODE_NL:    mapped = CODE_NL_R;
                default:    mapped = q_data.value;
            endcase
        end
    end

    assign load_data = '{kind: q_data.kind, value: mapped,
                         param_count: q_data.param_count,
                         closes_command: q_data.closes_command};

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_reg <= load_data;
        end
    end

    assign m_valid          = valid_reg;
    assign m_kind           = out_reg.kind;
    assign m_value          = out_reg.value;
    assign m_param_count    = out_reg.param_count;
    assign m_closes_command = out_reg.closes_command;

endmodule

// File: rtl/text_word_decrypt_tokenizer_top.sv
// ----------------------------------------------------------------------------
// text_word_decrypt_tokenizer_top
// Decrypts a stream of 16-bit text words and splits it into characters,
// commands, parameters and end-of-line marks.
// ----------------------------------------------------------------------------
// Usage:
//   input channel s_*: one encrypted word per transfer, with first_of_line
//   set on the first word of a line and line_index seeding the key there.
//   result channel m_*: zero or one result per input word (kind, value,
//   param_count, closes_command); command header and type words, and words
//   after the end of a line, give no result.
//   Throughput is one word per cycle while the queue is not full. A result
//   reaches m_valid through the queue and then the output register: the
//   front decrypts and classifies in the transfer cycle and writes the
//   queue, and the back loads the output register from the queue head.
//   When the receiver stalls, results collect in the queue (QUEUE_DEPTH
//   entries) plus the output register; s_ready drops only when the queue
//   is full, so a stall costs nothing until that point.
//   Reset empties the queue and output register, sets the key to its
//   line-zero seed and puts the parser in text phase.
// ----------------------------------------------------------------------------
module text_word_decrypt_tokenizer_top import twdt_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_first_of_line,
    input  logic [15:0] s_line_index,
    input  logic [15:0] s_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [15:0] m_value,
    output logic [15:0] m_param_count,
    output logic        m_closes_command
);

    logic      in_fire, push, full, q_valid, q_pop;
    twdt_res_t push_data, q_data;

    assign s_ready = !full;
    assign in_fire = s_valid && s_ready;

    // decrypt and classify
    twdt_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_fire       (in_fire),
        .first_of_line (s_first_of_line),
        .line_index    (s_line_index),
        .word          (s_word),
        .push          (push),
        .push_data     (push_data)
    );

    // decoupling queue
    twdt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .not_empty (q_valid),
        .pop       (q_pop),
        .pop_data  (q_data)
    );

    // remap and output register
    twdt_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_data           (q_data),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_value          (m_value),
        .m_param_count    (m_param_count),
        .m_closes_command (m_closes_command)
    );

endmodule
